FILE: rtl/rrbb_pkg.sv
// Package for the rotated rectangle bounding box block.
// Holds shared widths, angle constants, the quadrant code and the sine/cosine table builder.
`timescale 1ns / 1ps
package rrbb_pkg;

	localparam int TRIG_BITS_DEF       = 16;
	localparam int COORD_FRAC_BITS_DEF = 4;

	localparam int CTR_W   = 16;
	localparam int TEX_W   = 10;
	localparam int SCALE_W = 8;
	localparam int ANG_W   = 13;
	localparam int OUT_W   = 24;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd16;

	// angle units are 1/16 degree
	localparam logic [ANG_W-1:0] FULL_TURN    = 13'd5760;
	localparam logic [ANG_W-1:0] HALF_TURN    = 13'd2880;
	localparam logic [ANG_W-1:0] QUARTER_TURN = 13'd1440;
	localparam logic [ANG_W-1:0] THREE_QUARTER_TURN = 13'd4320;
	localparam int OCT_MAX = 720;
	localparam int OCT_W   = 10;
	localparam int REM_W   = 11;

	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quadrant_t;

	// each entry packs sine in [63:32] and cosine in [31:0], Q(tb) unsigned
	typedef logic [63:0] trig_rom_t [0:OCT_MAX];

	// Taylor series in Q30 over the first octant, rounded half up to tb bits
	function automatic trig_rom_t build_trig_rom(input int tb);
		trig_rom_t rom;
		logic [63:0] one;
		logic [63:0] half;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] c;
		one  = 64'd1 << 30;
		half = 64'd1 << (29 - tb);
		for (int r = 0; r <= OCT_MAX; r++) begin
			x  = (64'(r) * PI_Q30 + 64'd1440) / 64'd2880;
			x2 = (x * x) >> 30;
			// sine
			t = one - x2 / 64'd72;
			t = one - ((x2 * t) >> 30) / 64'd42;
			t = one - ((x2 * t) >> 30) / 64'd20;
			t = one - ((x2 * t) >> 30) / 64'd6;
			s = (((x * t) >> 30) + half) >> (30 - tb);
			// cosine
			t = one - x2 / 64'd90;
			t = one - ((x2 * t) >> 30) / 64'd56;
			t = one - ((x2 * t) >> 30) / 64'd30;
			t = one - ((x2 * t) >> 30) / 64'd12;
			t = one - ((x2 * t) >> 30) / 64'd2;
			c = (t + half) >> (30 - tb);
			rom[r] = {s[31:0], c[31:0]};
		end
		return rom;
	endfunction

endpackage

FILE: rtl/rrbb_if.sv
// Channel interfaces for the rotated rectangle bounding box block.
// Depends on rrbb_pkg for field widths.
`timescale 1ns / 1ps
interface rrbb_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [rrbb_pkg::SCALE_W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rrbb_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [rrbb_pkg::CTR_W-1:0] center_x;
	logic signed [rrbb_pkg::CTR_W-1:0] center_y;
	logic        [rrbb_pkg::TEX_W-1:0] tex_width;
	logic        [rrbb_pkg::TEX_W-1:0] tex_height;
	logic        [rrbb_pkg::ANG_W-1:0] angle;
	modport source (output valid, output center_x, output center_y, output tex_width,
		output tex_height, output angle, input ready);
	modport sink (input valid, input center_x, input center_y, input tex_width,
		input tex_height, input angle, output ready);
endinterface

interface rrbb_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [rrbb_pkg::OUT_W-1:0] min_x;
	logic signed [rrbb_pkg::OUT_W-1:0] min_y;
	logic signed [rrbb_pkg::OUT_W-1:0] max_x;
	logic signed [rrbb_pkg::OUT_W-1:0] max_y;
	modport source (output valid, output min_x, output min_y, output max_x, output max_y,
		input ready);
	modport sink (input valid, input min_x, input min_y, input max_x, input max_y,
		output ready);
endinterface

FILE: rtl/rotated_rect_bounding_box.sv
// Top level of the rotated rectangle bounding box block.
// Depends on rrbb_pkg, rrbb_if, rrbb_trig and rrbb_corner_cell.
//
// Usage:
//   cfg    : write channel for the scale register (unsigned, 4 fraction bits);
//            always ready, written on valid. Reset value is 1.0.
//   sprite : one transaction per sprite: centre, texture size, angle.
//   box    : one transaction per sprite: min/max x and y of the rotated corners.
// A sprite passes one stage for the angle fold and sine/cosine table read, one
// for the corner products, then a row of four corner cells that carry the
// running extremes, before its box is valid.
// Throughput is one sprite per cycle while box.ready is high; each stage moves
// whenever the stage after it is empty or moving, so bubbles are squeezed out.
// When box.ready is low the result holds and earlier stages keep filling until
// the row is full, after which sprite.ready drops.
// Reset clears all stage valid flags and loads the scale register; nothing is
// in flight afterward.
`timescale 1ns / 1ps
module rotated_rect_bounding_box #(
	parameter int TRIG_BITS       = rrbb_pkg::TRIG_BITS_DEF,
	parameter int COORD_FRAC_BITS = rrbb_pkg::COORD_FRAC_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	rrbb_cfg_if.sink    cfg,
	rrbb_in_if.sink     sprite,
	rrbb_out_if.source  box
);
	import rrbb_pkg::*;

	localparam int TW     = TRIG_BITS + 2;
	localparam int WW     = TEX_W + SCALE_W;
	localparam int PW     = WW + 1 + TW;
	localparam int RW     = PW + 3 + COORD_FRAC_BITS;
	localparam int SH     = 5 + TRIG_BITS;
	localparam int STAGES = 6;
	localparam int NCELL  = 4;

	logic [SCALE_W-1:0] scale_q;
	logic [STAGES:1]    vld_q;
	logic [STAGES:1]    en;

	// scale register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (cfg.valid) begin
			scale_q <= cfg.data;
		end
	end

	// stage enables: a stage loads when it is empty or its content moves on
	always_comb begin
		en[STAGES] = !vld_q[STAGES] || box.ready;
		for (int k = STAGES - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end
	assign sprite.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= sprite.valid;
			end
			for (int k = 2; k <= STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// stage 1: trig table, scaled sizes, centre
	logic signed [TW-1:0]    sin_val, cos_val;
	logic [WW-1:0]           w_s1, h_s1;
	logic signed [CTR_W-1:0] cx_s1, cy_s1;

	rrbb_trig #(.TRIG_BITS(TRIG_BITS)) u_trig (
		.clk     (clk),
		.en      (en[1]),
		.angle   (sprite.angle),
		.sin_val (sin_val),
		.cos_val (cos_val)
	);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			w_s1  <= WW'(sprite.tex_width) * WW'(scale_q);
			h_s1  <= WW'(sprite.tex_height) * WW'(scale_q);
			cx_s1 <= sprite.center_x;
			cy_s1 <= sprite.center_y;
		end
	end

	// stage 2: corner products
	logic signed [PW-1:0]    wc_s2, hs_s2, ws_s2, hc_s2;
	logic signed [CTR_W-1:0] cx_s2, cy_s2;
	logic signed [WW:0]      w_sg, h_sg;

	assign w_sg = $signed({1'b0, w_s1});
	assign h_sg = $signed({1'b0, h_s1});

	always_ff @(posedge clk) begin
		if (en[2]) begin
			wc_s2 <= w_sg * cos_val;
			hs_s2 <= h_sg * sin_val;
			ws_s2 <= w_sg * sin_val;
			hc_s2 <= h_sg * cos_val;
			cx_s2 <= cx_s1;
			cy_s2 <= cy_s1;
		end
	end

	// row of corner cells, stages 3 to 6
	logic signed [PW-1:0]    wc_c [0:NCELL];
	logic signed [PW-1:0]    hs_c [0:NCELL];
	logic signed [PW-1:0]    ws_c [0:NCELL];
	logic signed [PW-1:0]    hc_c [0:NCELL];
	logic signed [CTR_W-1:0] cx_c [0:NCELL];
	logic signed [CTR_W-1:0] cy_c [0:NCELL];
	logic signed [RW-1:0]    mnx_c [0:NCELL];
	logic signed [RW-1:0]    mny_c [0:NCELL];
	logic signed [RW-1:0]    mxx_c [0:NCELL];
	logic signed [RW-1:0]    mxy_c [0:NCELL];

	assign wc_c[0]  = wc_s2;
	assign hs_c[0]  = hs_s2;
	assign ws_c[0]  = ws_s2;
	assign hc_c[0]  = hc_s2;
	assign cx_c[0]  = cx_s2;
	assign cy_c[0]  = cy_s2;
	assign mnx_c[0] = '0;
	assign mny_c[0] = '0;
	assign mxx_c[0] = '0;
	assign mxy_c[0] = '0;

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		rrbb_corner_cell #(
			.PW    (PW),
			.RW    (RW),
			.SH    (SH),
			.FRAC  (COORD_FRAC_BITS),
			.NEG_X (k == 0 || k == 3),
			.NEG_Y (k >= 2),
			.FIRST (k == 0)
		) u_cell (
			.clk   (clk),
			.en    (en[3+k]),
			.wc_i  (wc_c[k]),
			.hs_i  (hs_c[k]),
			.ws_i  (ws_c[k]),
			.hc_i  (hc_c[k]),
			.cx_i  (cx_c[k]),
			.cy_i  (cy_c[k]),
			.mnx_i (mnx_c[k]),
			.mny_i (mny_c[k]),
			.mxx_i (mxx_c[k]),
			.mxy_i (mxy_c[k]),
			.wc_o  (wc_c[k+1]),
			.hs_o  (hs_c[k+1]),
			.ws_o  (ws_c[k+1]),
			.hc_o  (hc_c[k+1]),
			.cx_o  (cx_c[k+1]),
			.cy_o  (cy_c[k+1]),
			.mnx_o (mnx_c[k+1]),
			.mny_o (mny_c[k+1]),
			.mxx_o (mxx_c[k+1]),
			.mxy_o (mxy_c[k+1])
		);
	end

	// saturate to the output range
	localparam logic signed [RW-1:0] OUT_MAX = RW'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
	localparam logic signed [RW-1:0] OUT_MIN = RW'(-(64'sd1 <<< (OUT_W - 1)));

	function automatic logic signed [OUT_W-1:0] sat(input logic signed [RW-1:0] v);
		logic signed [RW-1:0] r;
		r = v;
		if (v > OUT_MAX) begin
			r = OUT_MAX;
		end else if (v < OUT_MIN) begin
			r = OUT_MIN;
		end
		return r[OUT_W-1:0];
	endfunction

	assign box.valid = vld_q[STAGES];
	assign box.min_x = sat(mnx_c[NCELL]);
	assign box.min_y = sat(mny_c[NCELL]);
	assign box.max_x = sat(mxx_c[NCELL]);
	assign box.max_y = sat(mxy_c[NCELL]);

endmodule

FILE: rtl/rrbb_trig.sv
// Angle folding, octant sine/cosine table and quadrant mapping (first pipeline stage).
// Depends on rrbb_pkg.
`timescale 1ns / 1ps
module rrbb_trig #(
	parameter int TRIG_BITS = rrbb_pkg::TRIG_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic [rrbb_pkg::ANG_W-1:0]       angle,
	output logic signed [TRIG_BITS+1:0]      sin_val,
	output logic signed [TRIG_BITS+1:0]      cos_val
);
	import rrbb_pkg::*;

	localparam int EW = TRIG_BITS + 1;
	localparam trig_rom_t TrigRom = build_trig_rom(TRIG_BITS);

	logic [ANG_W-1:0] ang_w;
	logic [ANG_W-1:0] ang_r;
	quadrant_t        quad;
	logic [REM_W-1:0] rem;
	logic [OCT_W-1:0] idx;
	logic             swap;

	logic [63:0] entry_s1;
	quadrant_t   quad_s1;
	logic        swap_s1;
	logic signed [TRIG_BITS+1:0] s0, c0;

	// wrap, split into quadrant and remainder, fold into first octant
	always_comb begin
		ang_w = (angle >= FULL_TURN) ? angle - FULL_TURN : angle;
		priority if (ang_w < QUARTER_TURN) begin
			quad  = QUAD_0;
			ang_r = ang_w;
		end else if (ang_w < HALF_TURN) begin
			quad  = QUAD_1;
			ang_r = ang_w - QUARTER_TURN;
		end else if (ang_w < THREE_QUARTER_TURN) begin
			quad  = QUAD_2;
			ang_r = ang_w - HALF_TURN;
		end else begin
			quad  = QUAD_3;
			ang_r = ang_w - THREE_QUARTER_TURN;
		end
		rem  = ang_r[REM_W-1:0];
		swap = (rem > REM_W'(OCT_MAX));
		idx  = swap ? OCT_W'(QUARTER_TURN[REM_W-1:0] - rem) : rem[OCT_W-1:0];
	end

	// registered table read
	always_ff @(posedge clk) begin
		if (en) begin
			entry_s1 <= TrigRom[idx];
			quad_s1  <= quad;
			swap_s1  <= swap;
		end
	end

	// octant swap and quadrant signs
	always_comb begin
		s0 = $signed({1'b0, swap_s1 ? entry_s1[0 +: EW] : entry_s1[32 +: EW]});
		c0 = $signed({1'b0, swap_s1 ? entry_s1[32 +: EW] : entry_s1[0 +: EW]});
		unique case (quad_s1)
			QUAD_0: begin
				cos_val = c0;
				sin_val = s0;
			end
			QUAD_1: begin
				cos_val = -s0;
				sin_val = c0;
			end
			QUAD_2: begin
				cos_val = -c0;
				sin_val = -s0;
			end
			default: begin
				cos_val = s0;
				sin_val = -c0;
			end
		endcase
	end

endmodule

FILE: rtl/rrbb_corner_cell.sv
// One corner cell: rotates one rectangle corner, rounds it onto the grid and
// folds it into the running min/max passed along the cell row. Depends on rrbb_pkg.
`timescale 1ns / 1ps
module rrbb_corner_cell #(
	parameter int PW    = 37,
	parameter int RW    = 44,
	parameter int SH    = 21,
	parameter int FRAC  = 4,
	parameter bit NEG_X = 1'b0,
	parameter bit NEG_Y = 1'b0,
	parameter bit FIRST = 1'b0
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [PW-1:0]              wc_i,
	input  logic signed [PW-1:0]              hs_i,
	input  logic signed [PW-1:0]              ws_i,
	input  logic signed [PW-1:0]              hc_i,
	input  logic signed [rrbb_pkg::CTR_W-1:0] cx_i,
	input  logic signed [rrbb_pkg::CTR_W-1:0] cy_i,
	input  logic signed [RW-1:0]              mnx_i,
	input  logic signed [RW-1:0]              mny_i,
	input  logic signed [RW-1:0]              mxx_i,
	input  logic signed [RW-1:0]              mxy_i,
	output logic signed [PW-1:0]              wc_o,
	output logic signed [PW-1:0]              hs_o,
	output logic signed [PW-1:0]              ws_o,
	output logic signed [PW-1:0]              hc_o,
	output logic signed [rrbb_pkg::CTR_W-1:0] cx_o,
	output logic signed [rrbb_pkg::CTR_W-1:0] cy_o,
	output logic signed [RW-1:0]              mnx_o,
	output logic signed [RW-1:0]              mny_o,
	output logic signed [RW-1:0]              mxx_o,
	output logic signed [RW-1:0]              mxy_o
);
	import rrbb_pkg::*;

	logic signed [PW:0]   wc_e, hs_e, ws_e, hc_e;
	logic signed [PW:0]   vx, vy;
	logic signed [RW-1:0] px, py, rx, ry;

	// corner rotation, grid scaling and round half up
	always_comb begin
		wc_e = (PW+1)'(wc_i);
		hs_e = (PW+1)'(hs_i);
		ws_e = (PW+1)'(ws_i);
		hc_e = (PW+1)'(hc_i);
		vx   = (NEG_X ? -wc_e : wc_e) - (NEG_Y ? -hs_e : hs_e);
		vy   = (NEG_X ? -ws_e : ws_e) + (NEG_Y ? -hc_e : hc_e);
		px   = (RW'(vx) <<< FRAC) + (RW'(1) <<< (SH - 1));
		py   = (RW'(vy) <<< FRAC) + (RW'(1) <<< (SH - 1));
		rx   = (px >>> SH) + RW'(cx_i);
		ry   = (py >>> SH) + RW'(cy_i);
	end

	// hand products, centre and running extremes to the next cell
	always_ff @(posedge clk) begin
		if (en) begin
			wc_o  <= wc_i;
			hs_o  <= hs_i;
			ws_o  <= ws_i;
			hc_o  <= hc_i;
			cx_o  <= cx_i;
			cy_o  <= cy_i;
			mnx_o <= (FIRST || rx < mnx_i) ? rx : mnx_i;
			mny_o <= (FIRST || ry < mny_i) ? ry : mny_i;
			mxx_o <= (FIRST || rx > mxx_i) ? rx : mxx_i;
			mxy_o <= (FIRST || ry > mxy_i) ? ry : mxy_i;
		end
	end

endmodule
